// File: hdl/ctg_pkg.sv
// Shared constants, types and helpers for the circular trajectory generator.
package ctg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_RADIUS       = 3'd2,
        CFG_ANGULAR_RATE = 3'd3,
        CFG_PHASE_OFFSET = 3'd4
    } cfg_reg_t;

    // two pi in Q.38 and derived residues
    localparam logic [40:0] TWO_PI_Q38 = 41'h1921FB54443;
    localparam logic [40:0] POW64_MOD  =
        41'(65'h1_0000_0000_0000_0000 % 65'(TWO_PI_Q38));

    // phase reduction: restoring steps of MOD_STEP_W bits over the low word bits
    localparam int MOD_STEP_W = 2;
    localparam int MOD_RADIX  = 1 << MOD_STEP_W;
    localparam int MOD_LOW_W  = 24;
    localparam int MOD_STEPS  = MOD_LOW_W / MOD_STEP_W;
    localparam int MOD_REM_W  = 41;
    localparam int MOD_VAL_W  = MOD_REM_W + MOD_STEP_W;
    localparam logic [MOD_VAL_W-1:0] MOD_MULT [MOD_RADIX] = '{
        MOD_VAL_W'(0),
        MOD_VAL_W'(TWO_PI_Q38),
        MOD_VAL_W'(TWO_PI_Q38) * MOD_VAL_W'(2),
        MOD_VAL_W'(TWO_PI_Q38) * MOD_VAL_W'(3)
    };

    localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;
    localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;
    localparam int ATAN_ENTRIES = 30;
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    localparam int SAT_IN_W = 42;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        if (v > SAT_IN_W'(64'sd2147483647))
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -SAT_IN_W'(64'sd2147483648))
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

// File: hdl/ctg_phase.sv
// Phase pipeline: rate times time, offset, reduction modulo two pi, wrap to +-pi.
module ctg_phase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [31:0]        elapsed_time,
    input  logic signed [31:0] angular_rate,
    input  logic signed [31:0] phase_offset,
    output logic               out_vld,
    output logic signed [31:0] heading
);

    localparam int STEPS  = ctg_pkg::MOD_STEPS;
    localparam int STEP_W = ctg_pkg::MOD_STEP_W;
    localparam int LOW_W  = ctg_pkg::MOD_LOW_W;
    localparam int REM_W  = ctg_pkg::MOD_REM_W;
    localparam int VAL_W  = ctg_pkg::MOD_VAL_W;
    localparam int LAT    = STEPS + 4;

    logic [LAT-1:0]     vld_reg;
    logic signed [63:0] prod_reg;
    logic signed [64:0] sum_reg;
    logic [REM_W-1:0]   rem_reg [STEPS];
    logic [LOW_W-1:0]   low_reg [STEPS-1];
    logic               sgn_reg [STEPS];
    logic [REM_W-1:0]   ph_reg;
    logic [REM_W-1:0]   ph_next;
    logic [REM_W:0]     ph_dif;
    logic [REM_W-1:0]   ph_wrap;
    logic [REM_W:0]     ph_rnd;
    logic [32:0]        ang_u;
    logic signed [31:0] heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= angular_rate * $signed({1'b0, elapsed_time});
            sum_reg  <= 65'(prod_reg) + (65'(phase_offset) <<< 9);
        end
    end

    // low word reduced a few bits per stage; the sign weight is folded in afterwards
    for (genvar k = 0; k < STEPS; k++)
    begin : g_mod
        logic [REM_W-1:0]  rem_in;
        logic [LOW_W-1:0]  low_in;
        logic              sgn_in;
        logic [VAL_W-1:0]  val;
        logic [STEP_W-1:0] sel;

        if (k == 0)
        begin : g_head
            assign rem_in = REM_W'(sum_reg[63:LOW_W]);
            assign low_in = sum_reg[LOW_W-1:0];
            assign sgn_in = sum_reg[64];
        end
        else
        begin : g_body
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign sgn_in = sgn_reg[k-1];
        end

        assign val = {rem_in, low_in[LOW_W-1 -: STEP_W]};

        always_comb
        begin
            sel = '0;
            for (int m = 1; m < ctg_pkg::MOD_RADIX; m++)
            begin
                if (val >= ctg_pkg::MOD_MULT[m])
                begin
                    sel = STEP_W'(m);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= REM_W'(val - ctg_pkg::MOD_MULT[sel]);
                sgn_reg[k] <= sgn_in;
            end
        end

        if (k < STEPS - 1)
        begin : g_low
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[k] <= low_in << STEP_W;
                end
            end
        end
    end

    // negative input: subtract 2^64 mod 2pi, then bring back into [0, 2pi)
    always_comb
    begin
        ph_dif  = (REM_W+1)'(rem_reg[STEPS-1]) - (REM_W+1)'(ctg_pkg::POW64_MOD);
        ph_wrap = REM_W'(ph_dif + (REM_W+1)'(ctg_pkg::TWO_PI_Q38));
        if (!sgn_reg[STEPS-1])
        begin
            ph_next = rem_reg[STEPS-1];
        end
        else if (ph_dif[REM_W])
        begin
            ph_next = ph_wrap;
        end
        else
        begin
            ph_next = ph_dif[REM_W-1:0];
        end
    end

    assign ph_rnd = (REM_W+1)'(ph_reg) + (REM_W+1)'(256);
    assign ang_u  = 33'(ph_rnd >> 9);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= ph_next;
            if (ang_u > 33'(ctg_pkg::PI_Q29))
            begin
                heading_reg <= 32'(ang_u - 33'(ctg_pkg::TWO_PI_Q29));
            end
            else
            begin
                heading_reg <= 32'(ang_u);
            end
        end
    end

    assign out_vld = vld_reg[LAT-1];
    assign heading = heading_reg;

endmodule

// File: hdl/ctg_cordic.sv
// Pipelined rotation-mode CORDIC with quadrant fold, one micro-rotation per stage.
module ctg_cordic #(
    parameter int STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [31:0] angle,
    output logic               out_vld,
    output logic signed [31:0] angle_out,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int N   = (STAGES < ctg_pkg::ATAN_ENTRIES) ? STAGES : ctg_pkg::ATAN_ENTRIES;
    localparam int LAT = N + 2;

    logic [LAT-1:0]     vld_reg;
    logic signed [31:0] ang_fold;
    logic               flip;
    logic signed [32:0] z0_reg;
    logic               fl_reg  [N+1];
    logic signed [31:0] ang_reg [N+1];
    logic signed [31:0] x_reg   [N];
    logic signed [31:0] y_reg   [N];
    logic signed [32:0] z_reg   [N-1];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] ang_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
        end
    end

    always_comb
    begin
        ang_fold = angle;
        flip     = 1'b0;
        if (angle > ctg_pkg::HALF_PI_Q29)
        begin
            ang_fold = angle - ctg_pkg::PI_Q29;
            flip     = 1'b1;
        end
        else if (angle < -ctg_pkg::HALF_PI_Q29)
        begin
            ang_fold = angle + ctg_pkg::PI_Q29;
            flip     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg     <= 33'(ang_fold) <<< 1;
            fl_reg[0]  <= flip;
            ang_reg[0] <= angle;
            for (int k = 1; k <= N; k++)
            begin
                fl_reg[k]  <= fl_reg[k-1];
                ang_reg[k] <= ang_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [32:0] zs;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [32:0] atn;

        if (i == 0)
        begin : g_first
            assign xs = ctg_pkg::CORDIC_GAIN;
            assign ys = '0;
            assign zs = z0_reg;
        end
        else
        begin : g_next
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
        end

        assign dx  = ys >>> i;
        assign dy  = xs >>> i;
        assign atn = $signed(33'(ctg_pkg::ATAN_Q30[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zs[32])
                begin
                    x_reg[i] <= xs - dx;
                    y_reg[i] <= ys + dy;
                end
                else
                begin
                    x_reg[i] <= xs + dx;
                    y_reg[i] <= ys - dy;
                end
            end
        end

        if (i < N - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i] <= zs[32] ? zs + atn : zs - atn;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg     <= fl_reg[N] ? -x_reg[N-1] : x_reg[N-1];
            sin_reg     <= fl_reg[N] ? -y_reg[N-1] : y_reg[N-1];
            ang_out_reg <= ang_reg[N];
        end
    end

    assign out_vld   = vld_reg[LAT-1];
    assign angle_out = ang_out_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

// File: hdl/circular_trajectory_generator.sv
// Top level of the circular trajectory generator: config registers and output math.
// Throughput: one transfer per cycle; the whole pipeline advances whenever the output
// register is empty or being read, so only the output consumer can hold it.
// Reset: config registers return to their defaults, all pipeline valid bits clear.
module circular_trajectory_generator #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // elapsed_time
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pos_x, pos_y, heading, vel_x, vel_y, acc_x, acc_y
    output logic [223:0]                      m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [ctg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ctg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POST_LAT = 5;

    logic               en;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] angular_rate_reg;
    logic signed [31:0] phase_offset_reg;
    logic signed [63:0] wsq_reg;
    logic signed [63:0] wsq_rnd;
    logic [30:0]        w2_reg;
    logic signed [31:0] w2_s;

    logic               ph_vld;
    logic signed [31:0] ph_heading;
    logic               cr_vld;
    logic signed [31:0] cr_angle;
    logic signed [31:0] cr_cos;
    logic signed [31:0] cr_sin;

    logic [POST_LAT-1:0] vq_reg;
    logic signed [31:0]  hd_reg [POST_LAT];
    logic signed [63:0]  prc_reg;
    logic signed [63:0]  prs_reg;
    logic signed [63:0]  rnd_c;
    logic signed [63:0]  rnd_s;
    logic signed [32:0]  rc_reg;
    logic signed [32:0]  rs_reg;
    logic signed [64:0]  mvx_reg;
    logic signed [64:0]  mvy_reg;
    logic signed [64:0]  max_reg;
    logic signed [64:0]  may_reg;
    logic signed [33:0]  px_reg;
    logic signed [33:0]  py_reg;
    logic signed [64:0]  rnd_vx;
    logic signed [64:0]  rnd_vy;
    logic signed [64:0]  rnd_ax;
    logic signed [64:0]  rnd_ay;
    logic signed [36:0]  vx_reg;
    logic signed [36:0]  vy_reg;
    logic signed [40:0]  ax_reg;
    logic signed [40:0]  ay_reg;
    logic signed [31:0]  pxs_reg;
    logic signed [31:0]  pys_reg;
    logic signed [31:0]  out_pos_x_reg;
    logic signed [31:0]  out_pos_y_reg;
    logic signed [31:0]  out_vel_x_reg;
    logic signed [31:0]  out_vel_y_reg;
    logic signed [31:0]  out_acc_x_reg;
    logic signed [31:0]  out_acc_y_reg;

    assign en            = !vq_reg[POST_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            radius_reg       <= 31'd3276800;
            angular_rate_reg <= 32'sd2684355;
            phase_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (ctg_pkg::cfg_reg_t'(cfg_index))
                ctg_pkg::CFG_CENTER_X:     center_x_reg     <= cfg_data;
                ctg_pkg::CFG_CENTER_Y:     center_y_reg     <= cfg_data;
                ctg_pkg::CFG_RADIUS:       radius_reg       <= cfg_data[30:0];
                ctg_pkg::CFG_ANGULAR_RATE: angular_rate_reg <= cfg_data;
                ctg_pkg::CFG_PHASE_OFFSET: phase_offset_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // rate squared, Q8.24, follows the rate register
    assign wsq_rnd = wsq_reg + 64'sd2147483648;
    assign w2_s    = $signed({1'b0, w2_reg});

    always_ff @(posedge clk)
    begin
        wsq_reg <= angular_rate_reg * angular_rate_reg;
        w2_reg  <= wsq_rnd[62:32];
    end

    ctg_phase u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (s_axis_tvalid),
        .elapsed_time (s_axis_tdata),
        .angular_rate (angular_rate_reg),
        .phase_offset (phase_offset_reg),
        .out_vld      (ph_vld),
        .heading      (ph_heading)
    );

    ctg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (ph_vld),
        .angle     (ph_heading),
        .out_vld   (cr_vld),
        .angle_out (cr_angle),
        .cos_out   (cr_cos),
        .sin_out   (cr_sin)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= '0;
        end
        else if (en)
        begin
            vq_reg <= {vq_reg[POST_LAT-2:0], cr_vld};
        end
    end

    assign rnd_c  = prc_reg + 64'sd536870912;
    assign rnd_s  = prs_reg + 64'sd536870912;
    assign rnd_vx = mvx_reg + 65'sd134217728;
    assign rnd_vy = mvy_reg + 65'sd134217728;
    assign rnd_ax = max_reg + 65'sd8388608;
    assign rnd_ay = may_reg + 65'sd8388608;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_reg[0] <= cr_angle;
            for (int k = 1; k < POST_LAT; k++)
            begin
                hd_reg[k] <= hd_reg[k-1];
            end

            prc_reg <= $signed({1'b0, radius_reg}) * cr_cos;
            prs_reg <= $signed({1'b0, radius_reg}) * cr_sin;

            rc_reg <= rnd_c[62:30];
            rs_reg <= rnd_s[62:30];

            mvx_reg <= rs_reg * angular_rate_reg;
            mvy_reg <= rc_reg * angular_rate_reg;
            max_reg <= rc_reg * w2_s;
            may_reg <= rs_reg * w2_s;
            px_reg  <= 34'(rc_reg) + 34'(center_x_reg);
            py_reg  <= 34'(rs_reg) + 34'(center_y_reg);

            vx_reg  <= rnd_vx[64:28];
            vy_reg  <= rnd_vy[64:28];
            ax_reg  <= rnd_ax[64:24];
            ay_reg  <= rnd_ay[64:24];
            pxs_reg <= ctg_pkg::sat32(ctg_pkg::SAT_IN_W'(px_reg));
            pys_reg <= ctg_pkg::sat32(ctg_pkg::SAT_IN_W'(py_reg));

            out_pos_x_reg <= pxs_reg;
            out_pos_y_reg <= pys_reg;
            out_vel_x_reg <= ctg_pkg::sat32(-ctg_pkg::SAT_IN_W'(vx_reg));
            out_vel_y_reg <= ctg_pkg::sat32(ctg_pkg::SAT_IN_W'(vy_reg));
            out_acc_x_reg <= ctg_pkg::sat32(-ctg_pkg::SAT_IN_W'(ax_reg));
            out_acc_y_reg <= ctg_pkg::sat32(-ctg_pkg::SAT_IN_W'(ay_reg));
        end
    end

    assign m_axis_tvalid = vq_reg[POST_LAT-1];
    assign m_axis_tdata  = {out_acc_y_reg, out_acc_x_reg, out_vel_y_reg, out_vel_x_reg,
                            hd_reg[POST_LAT-1], out_pos_y_reg, out_pos_x_reg};

endmodule

// File: hdl/ctg_checker.sv
// Port-level checks for the circular trajectory generator, bound to the top level.
module ctg_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata
);

    // input side moves exactly when the output register can move
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("s_axis_tready does not track output stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[95:64]) <= ctg_pkg::PI_Q29) &&
                          ($signed(m_axis_tdata[95:64]) >= -ctg_pkg::PI_Q29))
        else $error("heading outside +-pi");

    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result present right after reset");

    a_accept_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output stage empty");

endmodule

bind circular_trajectory_generator ctg_checker u_ctg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
